[hdl/assert_macros.svh]
// Assertion macros for the RTL, used by calendar_to_unix_time.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define C2U_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`define C2U_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define C2U_ASSERT(label, clk, rst_n, prop)

`define C2U_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

[hdl/c2u_pkg.sv]
`timescale 1ns / 1ps

package c2u_pkg;

    localparam int unsigned DAY_W = 16;
    localparam int unsigned HMS_W = 17;
    localparam int unsigned SEC_W = 33;
    localparam int unsigned DIFF_W = 15;
    localparam int unsigned DIV_W = 16;
    localparam int unsigned REM_W = 25;
    localparam int unsigned QUO_W = 10;
    localparam int unsigned MS_W = 42;
    localparam int unsigned US_W = 32;
    localparam int unsigned TZ_W = 18;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned QUO_STEPS = 10;
    localparam int unsigned LATENCY = 16;

    localparam logic [SEC_W-1:0] EPOCH_ADJ = 33'd946598400;
    localparam logic [HMS_W-1:0] SEC_PER_DAY = 17'd86400;
    localparam logic [QUO_W-1:0] MS_PER_S = 10'd1000;
    localparam logic [DIFF_W-1:0] PRESCALER_RESET = 15'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_PRESCALER  = 2'd0,
        CFG_TIMEZONE_OFFSET = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic [6:0]  year_since_2000;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [14:0] subsecond_count;
    } calendar_t;

    typedef struct packed {
        logic [MS_W-1:0] unix_ms;
        logic [US_W-1:0] unix_s;
    } result_t;

    typedef struct packed {
        logic              valid;
        logic [DAY_W-1:0]  day_count;
        logic [HMS_W-1:0]  hms;
        logic [DIFF_W-1:0] diff;
        logic              frac_ok;
    } date_t;

    typedef struct packed {
        logic              valid;
        logic [REM_W-1:0]  rem;
        logic [QUO_W-1:0]  quo;
        logic [MS_W-1:0]   ms_base;
        logic [US_W-1:0]   unix_s;
    } div_t;

endpackage

[hdl/c2u_date.sv]
`timescale 1ns / 1ps

module c2u_date (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  c2u_pkg::calendar_t           cal,
    input  logic [c2u_pkg::DIFF_W-1:0]   prescaler,
    output c2u_pkg::date_t               date
);

    function automatic logic [c2u_pkg::DAY_W-1:0] days_before_year(input logic [6:0] year);
        logic [c2u_pkg::DAY_W-1:0] base;
        logic [c2u_pkg::DAY_W-1:0] leaps;
        begin
            base = 16'(year) * 16'd365;
            leaps = 16'((8'(year) + 8'd3) >> 2);
            if (year > 7'd100)
            begin
                leaps = leaps - 16'd1;
            end
            return base + leaps;
        end
    endfunction

    function automatic logic [8:0] month_start(input logic [3:0] month);
        logic [8:0] days;
        begin
            case (month)
                4'd0, 4'd1: days = 9'd0;
                4'd2:       days = 9'd31;
                4'd3:       days = 9'd59;
                4'd4:       days = 9'd90;
                4'd5:       days = 9'd120;
                4'd6:       days = 9'd151;
                4'd7:       days = 9'd181;
                4'd8:       days = 9'd212;
                4'd9:       days = 9'd243;
                4'd10:      days = 9'd273;
                4'd11:      days = 9'd304;
                4'd12:      days = 9'd334;
                default:    days = 9'd365;
            endcase
            return days;
        end
    endfunction

    c2u_pkg::date_t calc_reg;
    c2u_pkg::date_t calc_next;
    logic           leap;

    always_comb
    begin
        leap = (cal.year_since_2000[1:0] == 2'd0) && (cal.year_since_2000 != 7'd100);
        calc_next.valid = in_valid;
        calc_next.day_count = days_before_year(cal.year_since_2000)
                            + 16'(month_start(cal.month))
                            + 16'(leap && (cal.month > 4'd2))
                            + 16'(cal.day);
        calc_next.hms = 17'(cal.hour) * 17'd3600
                      + 17'(cal.minute) * 17'd60
                      + 17'(cal.second);
        calc_next.frac_ok = (cal.subsecond_count <= prescaler);
        calc_next.diff = prescaler - cal.subsecond_count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calc_reg <= '0;
        end
        else
        begin
            calc_reg <= calc_next;
        end
    end

    assign date = calc_reg;

endmodule

[hdl/c2u_div_step.sv]
`timescale 1ns / 1ps

module c2u_div_step #(
    parameter int unsigned SHIFT = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [c2u_pkg::DIV_W-1:0]   divisor,
    input  c2u_pkg::div_t               d_in,
    output c2u_pkg::div_t               d_out
);

    c2u_pkg::div_t                  d_reg;
    c2u_pkg::div_t                  d_next;
    logic [c2u_pkg::REM_W-1:0]      trial;
    logic                           take;

    always_comb
    begin
        trial = c2u_pkg::REM_W'(divisor) << SHIFT;
        take = (d_in.rem >= trial);
        d_next = d_in;
        if (take)
        begin
            d_next.rem = d_in.rem - trial;
            d_next.quo = d_in.quo | (c2u_pkg::QUO_W'(1) << SHIFT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_reg <= '0;
        end
        else
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

[hdl/calendar_to_unix_time.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Converts a local calendar time to UTC Unix seconds and milliseconds.
// An item is taken at a rising edge with start high and busy low; busy stays
// low, so a new item may be started in every cycle.
// Each item gives one result, shown on result for exactly one cycle with done
// high. Results leave in the order the items came in. The receiver cannot stall.
// The pipeline consists of an input register, four stages of date and seconds
// arithmetic, a ten-stage restoring divider that forms the millisecond
// fraction one quotient bit per stage, and the output register.
// Throughput is one item per cycle.
// Registers are written through the cfg channel: index 0 is the sync
// prescaler, index 1 the timezone offset. cfg_ready is low while any item is
// in flight, so settings never change under an item.
// Reset empties the pipeline and sets the prescaler to 255 and the timezone
// offset to zero.

module calendar_to_unix_time (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  c2u_pkg::calendar_t               calendar,
    output logic                             done,
    output c2u_pkg::result_t                 result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [c2u_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [c2u_pkg::TZ_W-1:0]         cfg_data
);

    localparam int unsigned STEPS = c2u_pkg::QUO_STEPS;

    logic [c2u_pkg::DIFF_W-1:0]  prescaler_reg;
    logic [c2u_pkg::TZ_W-1:0]    tz_reg;
    logic [c2u_pkg::DIV_W-1:0]   divisor;

    logic                        in_valid_reg;
    c2u_pkg::calendar_t          cal_reg;
    c2u_pkg::date_t              date;

    logic                        c_valid_reg;
    logic [c2u_pkg::SEC_W-1:0]   day_sec_reg;
    logic [c2u_pkg::SEC_W-1:0]   day_sec_next;
    logic [c2u_pkg::HMS_W-1:0]   hms_reg;
    logic [c2u_pkg::REM_W-1:0]   num_c_reg;
    logic [c2u_pkg::REM_W-1:0]   num_c_next;

    logic                        d_valid_reg;
    logic [c2u_pkg::SEC_W-1:0]   utc_reg;
    logic [c2u_pkg::SEC_W-1:0]   utc_next;
    logic [c2u_pkg::REM_W-1:0]   num_d_reg;

    c2u_pkg::div_t               chain [0:STEPS];
    c2u_pkg::div_t               e_reg;
    c2u_pkg::div_t               e_next;

    logic                        done_reg;
    c2u_pkg::result_t            result_reg;
    c2u_pkg::result_t            result_next;
    logic                        pipe_active;
    logic                        accept;

    assign busy = 1'b0;
    assign accept = start && !busy;
    assign divisor = c2u_pkg::DIV_W'(prescaler_reg) + 16'd1;

    always_comb
    begin
        pipe_active = in_valid_reg || date.valid || c_valid_reg || d_valid_reg;
        for (int i = 0; i <= STEPS; i++)
        begin
            pipe_active = pipe_active || chain[i].valid;
        end
    end

    assign cfg_ready = !pipe_active;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescaler_reg <= c2u_pkg::PRESCALER_RESET;
            tz_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                c2u_pkg::CFG_SYNC_PRESCALER:  prescaler_reg <= cfg_data[c2u_pkg::DIFF_W-1:0];
                c2u_pkg::CFG_TIMEZONE_OFFSET: tz_reg <= cfg_data;
                default:                      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
            c_valid_reg <= date.valid;
            d_valid_reg <= c_valid_reg;
            done_reg <= chain[STEPS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cal_reg <= calendar;
        end
    end

    c2u_date u_date (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .cal       (cal_reg),
        .prescaler (prescaler_reg),
        .date      (date)
    );

    always_comb
    begin
        day_sec_next = c2u_pkg::SEC_W'(date.day_count) * c2u_pkg::SEC_W'(c2u_pkg::SEC_PER_DAY);
        if (date.frac_ok)
        begin
            num_c_next = c2u_pkg::REM_W'(date.diff) * c2u_pkg::REM_W'(c2u_pkg::MS_PER_S);
        end
        else
        begin
            num_c_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        day_sec_reg <= day_sec_next;
        hms_reg <= date.hms;
        num_c_reg <= num_c_next;
    end

    always_comb
    begin
        utc_next = c2u_pkg::SEC_W'(34'(day_sec_reg) + 34'(hms_reg)
                 + 34'(c2u_pkg::EPOCH_ADJ) - {{16{tz_reg[c2u_pkg::TZ_W-1]}}, tz_reg});
    end

    always_ff @(posedge clk)
    begin
        utc_reg <= utc_next;
        num_d_reg <= num_c_reg;
    end

    always_comb
    begin
        e_next.valid = d_valid_reg;
        e_next.rem = num_d_reg;
        e_next.quo = '0;
        e_next.ms_base = c2u_pkg::MS_W'(43'(utc_reg) * 43'(c2u_pkg::MS_PER_S));
        e_next.unix_s = utc_reg[c2u_pkg::US_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_reg <= '0;
        end
        else
        begin
            e_reg <= e_next;
        end
    end

    assign chain[0] = e_reg;

    for (genvar i = 0; i < STEPS; i++)
    begin : g_div
        c2u_div_step #(
            .SHIFT (STEPS - 1 - i)
        ) u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .divisor (divisor),
            .d_in    (chain[i]),
            .d_out   (chain[i+1])
        );
    end

    always_comb
    begin
        result_next.unix_ms = chain[STEPS].ms_base + c2u_pkg::MS_W'(chain[STEPS].quo);
        result_next.unix_s = chain[STEPS].unix_s;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done = done_reg;
    assign result = result_reg;

    `C2U_ASSERT(a_latency, clk, rst_n, accept |-> ##16 done)
    `C2U_ASSERT(a_quo_range, clk, rst_n, chain[STEPS].valid |-> chain[STEPS].quo < 10'd1000)
    `C2U_ASSERT(a_rem_range, clk, rst_n, chain[STEPS].valid |-> chain[STEPS].rem < 25'(divisor))
    `C2U_ASSERT(a_cfg_locked, clk, rst_n, pipe_active |=> $stable(prescaler_reg) && $stable(tz_reg))

endmodule

[bench/calendar_to_unix_time_test.sv]
`timescale 1ns / 1ps

module calendar_to_unix_time_test;

    localparam int PROBE_COUNT = 23;
    localparam int PHASE_COUNT = 8;
    localparam int RANDOM_PER_PHASE = 220;

    typedef struct packed {
        c2u_pkg::calendar_t        cal;
        logic                      known;
        logic [c2u_pkg::MS_W-1:0]  ms;
        logic [c2u_pkg::US_W-1:0]  s;
    } probe_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    c2u_pkg::calendar_t            calendar = '0;
    logic                          done;
    c2u_pkg::result_t              result;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [c2u_pkg::CFG_IDX_W-1:0] cfg_index = c2u_pkg::CFG_SYNC_PRESCALER;
    logic [c2u_pkg::TZ_W-1:0]      cfg_data = '0;

    logic [c2u_pkg::DIFF_W-1:0]    prescaler_now = c2u_pkg::PRESCALER_RESET;
    logic [c2u_pkg::TZ_W-1:0]      tz_now = '0;
    c2u_pkg::result_t              pending_times[$];
    int                            mismatch_count = 0;

    // Calendar fields (year, month, day, hour, minute, second, counter), then a known
    // flag with the typed-in result where it is plain to see, otherwise zeros.
    probe_t probes [0:PROBE_COUNT-1] = '{
        {7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 15'd255,
            1'b1, 42'd946684800000, 32'd946684800},
        {7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 15'd0,
            1'b1, 42'd946684800996, 32'd946684800},
        {7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 15'd32767,
            1'b1, 42'd946684800000, 32'd946684800},
        {7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 15'd256,
            1'b1, 42'd946684800000, 32'd946684800},
        {7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 15'd0, 1'b0, 42'd0, 32'd0},
        {7'd0, 4'd1, 5'd1, 5'd23, 6'd59, 6'd59, 15'd128, 1'b0, 42'd0, 32'd0},
        {7'd0, 4'd2, 5'd29, 5'd12, 6'd0, 6'd0, 15'd1, 1'b0, 42'd0, 32'd0},
        {7'd0, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0, 15'd254, 1'b0, 42'd0, 32'd0},
        {7'd0, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 15'd0, 1'b0, 42'd0, 32'd0},
        {7'd1, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 15'd100, 1'b0, 42'd0, 32'd0},
        {7'd4, 4'd2, 5'd29, 5'd6, 6'd30, 6'd15, 15'd17, 1'b0, 42'd0, 32'd0},
        {7'd38, 4'd1, 5'd19, 5'd3, 6'd14, 6'd8, 15'd200, 1'b0, 42'd0, 32'd0},
        {7'd99, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 15'd0, 1'b0, 42'd0, 32'd0},
        {7'd100, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0, 15'd64, 1'b0, 42'd0, 32'd0},
        {7'd104, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0, 15'd0, 1'b0, 42'd0, 32'd0},
        {7'd106, 4'd2, 5'd7, 5'd6, 6'd28, 6'd16, 15'd255, 1'b0, 42'd0, 32'd0},
        {7'd10, 4'd0, 5'd15, 5'd8, 6'd0, 6'd0, 15'd10, 1'b0, 42'd0, 32'd0},
        {7'd10, 4'd13, 5'd1, 5'd0, 6'd0, 6'd0, 15'd10, 1'b0, 42'd0, 32'd0},
        {7'd10, 4'd15, 5'd31, 5'd0, 6'd0, 6'd0, 15'd10, 1'b0, 42'd0, 32'd0},
        {7'd10, 4'd5, 5'd0, 5'd0, 6'd0, 6'd0, 15'd10, 1'b0, 42'd0, 32'd0},
        {7'd1, 4'd2, 5'd31, 5'd0, 6'd0, 6'd0, 15'd10, 1'b0, 42'd0, 32'd0},
        {7'd20, 4'd6, 5'd15, 5'd31, 6'd63, 6'd63, 15'd10, 1'b0, 42'd0, 32'd0},
        {7'd127, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 15'd32767, 1'b0, 42'd0, 32'd0}
    };

    calendar_to_unix_time u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .calendar  (calendar),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic bit is_leap(int unsigned greg_year);
        return ((greg_year % 4 == 0) && (greg_year % 100 != 0)) || (greg_year % 400 == 0);
    endfunction

    // Days before the given month in a common year; thirteen means the whole year.
    function automatic int days_before_month(int unsigned m);
        case (m)
            2: return 31;
            3: return 59;
            4: return 90;
            5: return 120;
            6: return 151;
            7: return 181;
            8: return 212;
            9: return 243;
            10: return 273;
            11: return 304;
            12: return 334;
            13: return 365;
            default: return 0;
        endcase
    endfunction

    function automatic c2u_pkg::result_t unix_time_of(c2u_pkg::calendar_t c);
        longint            days;
        longint            local_s;
        longint            utc_s;
        longint            frac_ms;
        longint            total_ms;
        longint            tz;
        int unsigned       m;
        c2u_pkg::result_t  r;
        days = 0;
        for (int unsigned y = 0; y < c.year_since_2000; y++)
        begin
            days += is_leap(2000 + y) ? 366 : 365;
        end
        m = (c.month > 13) ? 13 : c.month;
        days += days_before_month(m);
        if (m > 2 && is_leap(2000 + c.year_since_2000))
        begin
            days += 1;
        end
        days += longint'(c.day) - 1;
        local_s = days * 86400 + longint'(c.hour) * 3600 + longint'(c.minute) * 60
                  + longint'(c.second) + 946684800;
        tz = $signed(tz_now);
        utc_s = local_s - tz;
        frac_ms = 0;
        if (c.subsecond_count <= prescaler_now)
        begin
            frac_ms = (longint'(prescaler_now) - longint'(c.subsecond_count)) * 1000
                      / (longint'(prescaler_now) + 1);
        end
        total_ms = utc_s * 1000 + frac_ms;
        r.unix_ms = total_ms[c2u_pkg::MS_W-1:0];
        r.unix_s = utc_s[c2u_pkg::US_W-1:0];
        return r;
    endfunction

    function automatic c2u_pkg::calendar_t random_calendar();
        c2u_pkg::calendar_t  c;
        int unsigned         month_days;
        if ($urandom_range(0, 99) < 85)
        begin
            c.year_since_2000 = 7'($urandom_range(0, 99));
            c.month = 4'($urandom_range(1, 12));
            month_days = days_before_month(c.month + 1) - days_before_month(c.month);
            if (c.month == 2 && is_leap(2000 + c.year_since_2000))
            begin
                month_days += 1;
            end
            c.day = 5'($urandom_range(1, month_days));
            c.hour = 5'($urandom_range(0, 23));
            c.minute = 6'($urandom_range(0, 59));
            c.second = 6'($urandom_range(0, 59));
            if ($urandom_range(0, 7) == 0)
            begin
                c.subsecond_count = 15'($urandom_range(0, 32767));
            end
            else
            begin
                c.subsecond_count = 15'($urandom_range(0, prescaler_now));
            end
        end
        else
        begin
            c.year_since_2000 = 7'($urandom_range(0, 127));
            c.month = 4'($urandom_range(0, 15));
            c.day = 5'($urandom_range(0, 31));
            c.hour = 5'($urandom_range(0, 31));
            c.minute = 6'($urandom_range(0, 63));
            c.second = 6'($urandom_range(0, 63));
            c.subsecond_count = 15'($urandom_range(0, 32767));
        end
        return c;
    endfunction

    task automatic send_time(c2u_pkg::calendar_t c, logic use_typed, c2u_pkg::result_t typed,
                             int idle_pct);
        start <= 1'b1;
        calendar <= c;
        do @(posedge clk); while (busy);
        pending_times.push_back(use_typed ? typed : unix_time_of(c));
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    task automatic set_config(logic [c2u_pkg::DIFF_W-1:0] prescaler,
                              logic [c2u_pkg::TZ_W-1:0] tz);
        cfg_valid <= 1'b1;
        cfg_index <= c2u_pkg::CFG_SYNC_PRESCALER;
        cfg_data <= c2u_pkg::TZ_W'(prescaler);
        do @(posedge clk); while (!cfg_ready);
        prescaler_now = prescaler;
        cfg_index <= c2u_pkg::CFG_TIMEZONE_OFFSET;
        cfg_data <= tz;
        do @(posedge clk); while (!cfg_ready);
        tz_now = tz;
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin : check_results
        c2u_pkg::result_t want;
        if (rst_n && done)
        begin
            if (pending_times.size() == 0)
            begin
                $display("%0t: result with none expected, unix_ms %0d unix_s %0d",
                         $time, result.unix_ms, result.unix_s);
                mismatch_count++;
            end
            else
            begin
                want = pending_times.pop_front();
                if (result.unix_ms !== want.unix_ms)
                begin
                    $display("%0t: unix_ms expected %0d, got %0d",
                             $time, want.unix_ms, result.unix_ms);
                    mismatch_count++;
                end
                if (result.unix_s !== want.unix_s)
                begin
                    $display("%0t: unix_s expected %0d, got %0d",
                             $time, want.unix_s, result.unix_s);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        logic [c2u_pkg::DIFF_W-1:0] prescaler_plan [PHASE_COUNT];
        logic [c2u_pkg::TZ_W-1:0]   tz_plan [PHASE_COUNT];
        int                         idle_pct;
        c2u_pkg::result_t           typed;
        prescaler_plan[1] = 15'd0;
        tz_plan[1] = -18'sd86400;
        prescaler_plan[2] = 15'd32767;
        tz_plan[2] = 18'sd86400;
        prescaler_plan[3] = 15'd1;
        tz_plan[3] = 18'sd3600;
        prescaler_plan[4] = 15'($urandom_range(0, 32767));
        tz_plan[4] = c2u_pkg::TZ_W'(int'($urandom_range(0, 172800)) - 86400);
        prescaler_plan[5] = 15'($urandom_range(0, 32767));
        tz_plan[5] = 18'h20000;
        prescaler_plan[6] = 15'($urandom_range(2, 1000));
        tz_plan[6] = 18'h1FFFF;
        prescaler_plan[7] = c2u_pkg::PRESCALER_RESET;
        tz_plan[7] = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < PROBE_COUNT; i++)
        begin
            typed.unix_ms = probes[i].ms;
            typed.unix_s = probes[i].s;
            send_time(probes[i].cal, probes[i].known, typed, 30);
        end

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            if (p != 0)
            begin
                start <= 1'b0;
                while (pending_times.size() != 0) @(posedge clk);
                set_config(prescaler_plan[p], tz_plan[p]);
            end
            if (p == PHASE_COUNT - 1 || p % 3 == 1)
            begin
                idle_pct = 0;
            end
            else
            begin
                idle_pct = (p % 3 == 2) ? 50 : 20;
            end
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                send_time(random_calendar(), 1'b0, typed, idle_pct);
            end
        end

        start <= 1'b0;
        while (pending_times.size() != 0) @(posedge clk);
        repeat (c2u_pkg::LATENCY + 4) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/c2u_pkg.sv
hdl/c2u_date.sv
hdl/c2u_div_step.sv
hdl/calendar_to_unix_time.sv
bench/calendar_to_unix_time_test.sv
